// ===== design/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the nonpreemptive priority scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  job_id;
    logic [7:0]  job_priority;
    logic [15:0] burst_time;
  } in_item_t;

  typedef struct packed {
    logic        job_done;
    logic [7:0]  done_id;
    logic [31:0] done_time;
    logic        cpu_busy;
    logic [7:0]  running_id;
    logic        arrival_rejected;
    logic [4:0]  queued_count;
    logic [31:0] clock_now;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
  } q_entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } q_cmd_t;

endpackage

// ===== design/nps_queue.sv =====
// ----------------------------------------------------------------------------
// nps_queue
// Shift-register ready queue kept sorted by priority, FIFO among equals.
// ----------------------------------------------------------------------------
module nps_queue
  import nps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  q_cmd_t            cmd,
  input  q_entry_t          new_entry,
  output q_entry_t          head,
  output logic [FILL_W-1:0] fill,
  output logic              full
);

  q_entry_t          q_r   [QUEUE_DEPTH];
  q_entry_t          q_nxt [QUEUE_DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              le    [QUEUE_DEPTH];

  assign head = q_r[0];
  assign fill = fill_r;
  assign full = (fill_r == FILL_W'(QUEUE_DEPTH));

  // le[k]: occupied cell that stays put on insert (prefix of the queue)
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      le[k] = (k < int'(fill_r)) && (q_r[k].prio <= new_entry.prio);
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      q_nxt[k] = q_r[k];
    end
    if (cmd.ins && !full) begin
      fill_nxt = fill_r + 1'b1;
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
        if (le[k]) begin
          q_nxt[k] = q_r[k];
        end else if (k == 0) begin
          q_nxt[k] = new_entry;
        end else if (le[k-1]) begin
          q_nxt[k] = new_entry;
        end else begin
          q_nxt[k] = q_r[k-1];
        end
      end
    end else if (cmd.pop && fill_r != '0) begin
      fill_nxt = fill_r - 1'b1;
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
        q_nxt[k] = q_r[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      q_r[k] <= q_nxt[k];
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins && cmd.pop))
    else $error("insert and pop in the same cycle");

endmodule

// ===== design/nonpreemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// Highest-priority-first, run-to-completion job scheduler with one shared
// saturating clock adder driven by a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: an arrival moves from idle to the output state; a tick steps
//   through dispatch at the transfer, context add, run step and output.
//   The output state holds while an untaken result is still pending.
// Only one request is in flight: in_ready is high in idle alone, so the
//   sequencer can share the single 32-bit saturating adder.
// Reset (rst_n low, synchronous) empties the queue, clears the running job,
//   zeroes the clock and the context switch cost.
module nonpreemptive_priority_scheduler
  import nps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CTX  = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  cost_r;
  logic        run_valid_r, run_valid_nxt;
  logic [7:0]  run_id_r, run_id_nxt;
  logic [15:0] run_rem_r, run_rem_nxt;
  logic        started_r, started_nxt;
  logic [31:0] clock_r, clock_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  done_id_r, done_id_nxt;
  logic [31:0] done_time_r, done_time_nxt;
  logic        rej_r, rej_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  q_cmd_t            q_cmd;
  q_entry_t          q_new;
  q_entry_t          q_head;
  logic [FILL_W-1:0] q_fill;
  logic              q_full;

  // shared saturating clock adder
  logic [31:0] addend;
  logic [32:0] add_sum;
  logic [31:0] add_sat;

  assign add_sum = {1'b0, clock_r} + {1'b0, addend};
  assign add_sat = add_sum[32] ? '1 : add_sum[31:0];

  assign q_new.id    = in_data.job_id;
  assign q_new.prio  = in_data.job_priority;
  assign q_new.burst = in_data.burst_time;

  nps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .new_entry (q_new),
    .head      (q_head),
    .fill      (q_fill),
    .full      (q_full)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    run_valid_nxt = run_valid_r;
    run_id_nxt    = run_id_r;
    run_rem_nxt   = run_rem_r;
    started_nxt   = started_r;
    clock_nxt     = clock_r;
    done_nxt      = done_r;
    done_id_nxt   = done_id_r;
    done_time_nxt = done_time_r;
    rej_nxt       = rej_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_cmd         = '0;
    addend        = 32'd1;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          done_nxt      = 1'b0;
          done_id_nxt   = '0;
          done_time_nxt = '0;
          rej_nxt       = 1'b0;
          if (in_data.req_type == REQ_ARRIVAL) begin
            if (q_full) begin
              rej_nxt = 1'b1;
            end else begin
              q_cmd.ins = 1'b1;
            end
            state_nxt = ST_FIN;
          end else begin
            if (!run_valid_r && q_fill != '0) begin
              q_cmd.pop     = 1'b1;
              run_valid_nxt = 1'b1;
              run_id_nxt    = q_head.id;
              run_rem_nxt   = q_head.burst;
              started_nxt   = 1'b0;
            end
            state_nxt = ST_CTX;
          end
        end
      end
      ST_CTX: begin
        addend = {24'd0, cost_r};
        if (run_valid_r && !started_r) begin
          clock_nxt   = add_sat;
          started_nxt = 1'b1;
        end
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (run_valid_r) begin
          if (run_rem_r != '0) begin
            run_rem_nxt = run_rem_r - 1'b1;
            clock_nxt   = add_sat;
          end
          if (run_rem_nxt == '0) begin
            done_nxt      = 1'b1;
            done_id_nxt   = run_id_r;
            done_time_nxt = clock_nxt;
            run_valid_nxt = 1'b0;
            started_nxt   = 1'b0;
          end
        end else begin
          clock_nxt = add_sat;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.job_done         = done_r;
          out_nxt.done_id          = done_id_r;
          out_nxt.done_time        = done_time_r;
          out_nxt.cpu_busy         = run_valid_r;
          out_nxt.running_id       = run_valid_r ? run_id_r : '0;
          out_nxt.arrival_rejected = rej_r;
          out_nxt.queued_count     = 5'(q_fill);
          out_nxt.clock_now        = clock_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cost_r      <= '0;
      run_valid_r <= 1'b0;
      run_id_r    <= '0;
      run_rem_r   <= '0;
      started_r   <= 1'b0;
      clock_r     <= '0;
      done_r      <= 1'b0;
      done_id_r   <= '0;
      done_time_r <= '0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        cost_r <= cfg_wr_data;
      end
      run_valid_r <= run_valid_nxt;
      run_id_r    <= run_id_nxt;
      run_rem_r   <= run_rem_nxt;
      started_r   <= started_nxt;
      clock_r     <= clock_nxt;
      done_r      <= done_nxt;
      done_id_r   <= done_id_nxt;
      done_time_r <= done_time_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  a_started_valid: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> run_valid_r)
    else $error("started flag without a running job");

  a_clock_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> clock_r >= $past(clock_r))
    else $error("scheduler clock went backwards");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.job_done |-> !out_r.cpu_busy && !out_r.arrival_rejected)
    else $error("finished job still shown as running");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nonpreemptive priority scheduler. A directed
// table covers an idle tick, a zero burst, tie order and an arrival during a
// run; a full-queue rejection follows. Random arrival/tick mixes run under
// several context-switch costs. Every result is compared field by field against
// its pinned row or an in-bench scheduler model; both channels stall randomly.
// ----------------------------------------------------------------------------
module tb;
  import nps_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MIX_ITEMS   = 210;

  typedef struct packed {
    in_item_t  item;
    logic      pinned;
    out_item_t want;
  } dir_row_t;

  // Reset cost is 0; clock values follow directly from the bursts.
  localparam dir_row_t DIR_ROWS [14] = '{
    '{'{REQ_TICK,    8'h00, 8'h00, 16'h0000}, 1'b1,
      '{1'b0, 8'h00, 32'd0, 1'b0, 8'h00, 1'b0, 5'd0, 32'd1}},
    '{'{REQ_ARRIVAL, 8'hFF, 8'hFF, 16'h0003}, 1'b1,
      '{1'b0, 8'h00, 32'd0, 1'b0, 8'h00, 1'b0, 5'd1, 32'd1}},
    '{'{REQ_ARRIVAL, 8'h00, 8'h00, 16'h0000}, 1'b1,
      '{1'b0, 8'h00, 32'd0, 1'b0, 8'h00, 1'b0, 5'd2, 32'd1}},
    '{'{REQ_ARRIVAL, 8'h5A, 8'hFF, 16'h0001}, 1'b1,
      '{1'b0, 8'h00, 32'd0, 1'b0, 8'h00, 1'b0, 5'd3, 32'd1}},
    '{'{REQ_ARRIVAL, 8'hA5, 8'h80, 16'h0002}, 1'b1,
      '{1'b0, 8'h00, 32'd0, 1'b0, 8'h00, 1'b0, 5'd4, 32'd1}},
    // zero burst finishes on dispatch without a clock step
    '{'{REQ_TICK,    8'hC3, 8'h3C, 16'hFFFF}, 1'b1,
      '{1'b1, 8'h00, 32'd1, 1'b0, 8'h00, 1'b0, 5'd3, 32'd1}},
    '{'{REQ_TICK,    8'h00, 8'h00, 16'h0000}, 1'b1,
      '{1'b0, 8'h00, 32'd0, 1'b1, 8'hA5, 1'b0, 5'd2, 32'd2}},
    '{'{REQ_ARRIVAL, 8'h11, 8'h00, 16'h0001}, 1'b1,
      '{1'b0, 8'h00, 32'd0, 1'b1, 8'hA5, 1'b0, 5'd3, 32'd2}},
    '{'{REQ_TICK,    8'h00, 8'h00, 16'h0000}, 1'b1,
      '{1'b1, 8'hA5, 32'd3, 1'b0, 8'h00, 1'b0, 5'd3, 32'd3}},
    '{'{REQ_TICK,    8'h00, 8'h00, 16'h0000}, 1'b1,
      '{1'b1, 8'h11, 32'd4, 1'b0, 8'h00, 1'b0, 5'd2, 32'd4}},
    '{'{REQ_TICK,    8'h00, 8'h00, 16'h0000}, 1'b0, '0},
    '{'{REQ_TICK,    8'h00, 8'h00, 16'h0000}, 1'b0, '0},
    '{'{REQ_TICK,    8'h00, 8'h00, 16'h0000}, 1'b1,
      '{1'b1, 8'hFF, 32'd7, 1'b0, 8'h00, 1'b0, 5'd1, 32'd7}},
    // equal priority: 5A arrived after FF, so it runs last
    '{'{REQ_TICK,    8'h00, 8'h00, 16'h0000}, 1'b1,
      '{1'b1, 8'h5A, 32'd8, 1'b0, 8'h00, 1'b0, 5'd0, 32'd8}}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  // scheduler model state
  q_entry_t    ready_jobs [QUEUE_DEPTH];
  int unsigned ready_fill = 0;
  logic        job_active = 1'b0;
  logic [7:0]  job_active_id = 8'h00;
  logic [15:0] job_left = 16'h0000;
  logic        job_begun = 1'b0;
  logic [31:0] sched_time = 32'd0;
  logic [7:0]  switch_cost = 8'h00;

  out_item_t sched_expect [$];
  int        fail_count = 0;
  int        cycle_count = 0;
  bit        tx_calm = 1'b0;

  nonpreemptive_priority_scheduler DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] time_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic sched_predict(input in_item_t it, output out_item_t r);
    int       pos;
    int       k;
    q_entry_t head;
    r = '0;
    if (it.req_type == REQ_ARRIVAL) begin
      if (ready_fill >= QUEUE_DEPTH) begin
        r.arrival_rejected = 1'b1;
      end else begin
        pos = ready_fill;
        while (pos > 0 && ready_jobs[pos-1].prio > it.job_priority) begin
          ready_jobs[pos] = ready_jobs[pos-1];
          pos--;
        end
        ready_jobs[pos].id    = it.job_id;
        ready_jobs[pos].prio  = it.job_priority;
        ready_jobs[pos].burst = it.burst_time;
        ready_fill++;
      end
    end else begin
      if (!job_active && ready_fill > 0) begin
        head = ready_jobs[0];
        for (k = 1; k < ready_fill; k++) ready_jobs[k-1] = ready_jobs[k];
        ready_fill--;
        job_active    = 1'b1;
        job_active_id = head.id;
        job_left      = head.burst;
        job_begun     = 1'b0;
      end
      if (job_active) begin
        if (!job_begun) begin
          sched_time = time_add(sched_time, {24'd0, switch_cost});
          job_begun  = 1'b1;
        end
        if (job_left > 0) begin
          job_left--;
          sched_time = time_add(sched_time, 32'd1);
        end
        if (job_left == 0) begin
          r.job_done  = 1'b1;
          r.done_id   = job_active_id;
          r.done_time = sched_time;
          job_active  = 1'b0;
          job_begun   = 1'b0;
        end
      end else begin
        sched_time = time_add(sched_time, 32'd1);
      end
    end
    r.cpu_busy     = job_active;
    r.running_id   = job_active ? job_active_id : 8'h00;
    r.queued_count = ready_fill[4:0];
    r.clock_now    = sched_time;
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (sched_expect.size() == 0) begin
      $error("result transfer with no item pending");
      fail_count++;
      return;
    end
    want = sched_expect.pop_front();
    check_field("job_done",         32'(want.job_done),         32'(got.job_done));
    check_field("done_id",          32'(want.done_id),          32'(got.done_id));
    check_field("done_time",        want.done_time,             got.done_time);
    check_field("cpu_busy",         32'(want.cpu_busy),         32'(got.cpu_busy));
    check_field("running_id",       32'(want.running_id),       32'(got.running_id));
    check_field("arrival_rejected", 32'(want.arrival_rejected),
                32'(got.arrival_rejected));
    check_field("queued_count",     32'(want.queued_count),     32'(got.queued_count));
    check_field("clock_now",        want.clock_now,             got.clock_now);
  endtask

  // Valid stays high after a transfer; the next call either reuses it or drops it.
  task automatic send_item(input in_item_t it, input bit pinned, input out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sched_predict(it, predicted);
    sched_expect.insert(sched_expect.size(), pinned ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sched_expect.size() != 0) @(posedge clk);
  endtask

  task automatic set_switch_cost(input logic [7:0] cost);
    drain_results();
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cost;
    switch_cost = cost;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_mix(input int n);
    int       i;
    int       arr_pct;
    in_item_t it;
    arr_pct = 50;
    for (i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: arr_pct = 25;
          1: arr_pct = 50;
          default: arr_pct = 75;
        endcase
        tx_calm = ($urandom_range(0, 3) == 0);
      end
      it.req_type     = ($urandom_range(0, 99) < arr_pct) ? REQ_ARRIVAL : REQ_TICK;
      it.job_id       = 8'($urandom);
      it.job_priority = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom);
      if (it.req_type == REQ_ARRIVAL && ready_fill >= QUEUE_DEPTH)
        it.burst_time = 16'($urandom);  // rejected anyway, so any length
      else begin
        case ($urandom_range(0, 19))
          0, 1, 2:        it.burst_time = 16'd0;
          3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
                          it.burst_time = 16'($urandom_range(1, 4));
          14, 15, 16, 17, 18:
                          it.burst_time = 16'($urandom_range(5, 16));
          default:        it.burst_time = 16'($urandom_range(17, 64));
        endcase
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  // result side: random stalls, one long hold-off to back up the block
  initial begin
    int   hold;
    int   got_count;
    bit   rx_calm;
    logic next_ready;
    hold      = 0;
    got_count = 0;
    rx_calm   = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_valid && out_ready) begin
        check_result(out_data);
        got_count++;
        if (got_count % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        if (got_count == 150) hold = 300;
      end
      if (hold > 0) begin
        next_ready = 1'b0;
        hold--;
      end else begin
        next_ready = 1'b1;
        if (!rx_calm) hold = pick_gap();
      end
      out_ready <= next_ready;
      @(posedge clk);
    end
  end

  initial begin
    int       i;
    in_item_t it;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < $size(DIR_ROWS); i++)
      send_item(DIR_ROWS[i].item, DIR_ROWS[i].pinned, DIR_ROWS[i].want);

    // fill the queue with tied priorities, then one arrival too many
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      it.req_type     = REQ_ARRIVAL;
      it.job_id       = 8'h80 | i[7:0];
      it.job_priority = 8'(i % 4);
      it.burst_time   = 16'(i % 3);
      send_item(it, 1'b0, '0);
    end
    it.req_type     = REQ_ARRIVAL;
    it.job_id       = 8'hFF;
    it.job_priority = 8'h00;
    it.burst_time   = 16'hFFFF;
    send_item(it, 1'b1,
              '{1'b0, 8'h00, 32'd0, 1'b0, 8'h00, 1'b1, 5'(QUEUE_DEPTH), 32'd8});

    set_switch_cost(8'hFF);
    run_mix(MIX_ITEMS);
    set_switch_cost(8'($urandom_range(2, 254)));
    run_mix(MIX_ITEMS);
    set_switch_cost(8'h00);
    run_mix(MIX_ITEMS);
    set_switch_cost(8'h01);
    run_mix(MIX_ITEMS);

    // long bursts left waiting in the queue at the end
    for (i = 0; i < 6; i++) begin
      it.req_type     = REQ_ARRIVAL;
      it.job_id       = 8'($urandom);
      it.job_priority = 8'($urandom);
      it.burst_time   = (i == 0) ? 16'hFFFF : 16'($urandom);
      send_item(it, 1'b0, '0);
    end

    drain_results();
    repeat (12) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== nonpreemptive_priority_scheduler.f =====
design/nps_pkg.sv
design/nps_queue.sv
design/nonpreemptive_priority_scheduler.sv
test/tb.sv
